// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("port check failed");

// next-cycle implication
`define AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("port check failed");

`endif

// File: hdl/lcn_pkg.sv
// shared types and constants for the local contrast normalizer
package lcn_pkg;

	localparam logic [1:0] REG_IMG_WIDTH     = 2'd0;
	localparam logic [1:0] REG_IMG_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

	// 0.0001 + 0.01 in units of 2^-28
	localparam logic [21:0] BIAS_Q28 = 22'd2711199;

	localparam int PIX_W = 16;
	localparam int OUT_W = 24;
	// widest dividend: |p| * 2^28 plus half the divisor
	localparam int NUM_W = 45;
	localparam int FRAC_SHIFT = 28;
	localparam logic [OUT_W-1:0] OUT_POS_MAX = 24'h7FFFFF;
	localparam logic [OUT_W-1:0] OUT_NEG_MIN = 24'h800000;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [1:0] {
		DK_LOAD  = 2'd0,
		DK_DRAIN = 2'd1,
		DK_SD    = 2'd2,
		DK_QUO   = 2'd3
	} div_kind_t;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_DIV  = 12'b000000000010,
		ST_LDWR = 12'b000000000100,
		ST_WSET = 12'b000000001000,
		ST_WIN  = 12'b000000010000,
		ST_MULN = 12'b000000100000,
		ST_MULS = 12'b000001000000,
		ST_SUBD = 12'b000010000000,
		ST_SQRT = 12'b000100000000,
		ST_DENS = 12'b001000000000,
		ST_RND  = 12'b010000000000,
		ST_OUT  = 12'b100000000000
	} state_t;

endpackage

// File: hdl/local_contrast_normalize.sv
// local contrast normalizer top: sequencer around one shared add/subtract unit
// load: bit-serial raster-index division through the shared unit, then the frame-store write
// drain: position division, window reads (one frame-store read a cycle), n*Q and S*S
//   multiplies (n = window pixels), subtract, root, SD division, rounding, quotient division
// busy stays high while an item is worked; one result strobe, receiver cannot stall
// arst_n clears sequencer, counters and config registers (256 x 256, radius 3); datapath and store are not cleared
module local_contrast_normalize #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 7
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             req_type,
	input  logic signed [lcn_pkg::PIX_W-1:0] pixel_in,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [8:0]                       cfg_data,
	output logic                             strobe,
	output logic signed [lcn_pkg::OUT_W-1:0] norm_value,
	output logic                             last_pixel
);
	// geometry widths
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int RDW   = $clog2(MAX_RADIUS + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int MAW   = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int BW0   = (YW > XW) ? YW : XW;
	localparam int BW    = ((BW0 > RDW) ? BW0 : RDW) + 1;
	// arithmetic widths
	localparam int NW    = $clog2(4 * MAX_RADIUS * MAX_RADIUS + 1);
	localparam int SW    = lcn_pkg::PIX_W + NW;
	localparam int QW    = 31 + NW;
	localparam int DW    = QW + NW;
	localparam int RW    = (DW + 1) / 2;
	localparam int DENW  = RW + 15;
	localparam int NUMW  = lcn_pkg::NUM_W;
	localparam int UW0   = (DW > NUMW) ? DW : NUMW;
	localparam int UW    = UW0 + (UW0 % 2);
	localparam int CTW   = $clog2(NUMW + 1);
	// register reset values, clamped into range
	localparam int W_RST = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
	localparam int H_RST = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;
	localparam int R_RST = (3 > MAX_RADIUS) ? MAX_RADIUS : 3;

	lcn_pkg::state_t    st_q;
	lcn_pkg::div_kind_t kind_q;

	// configuration, stored already clamped
	logic [WW-1:0]  w_q;
	logic [HW-1:0]  h_q;
	logic [RDW-1:0] rad_q;
	logic [WW-1:0]  cfg_w;
	logic [HW-1:0]  cfg_h;
	logic [RDW-1:0] cfg_r;

	logic [CW-1:0] load_cnt_q;
	logic [CW-1:0] emit_q;
	logic [CW-1:0] total;
	logic          accept;
	logic          strobe_q;
	logic [CTW-1:0] cnt_q;

	// shared unit operands
	logic [UW-1:0]    alu_a;
	logic [UW-1:0]    alu_b;
	lcn_pkg::alu_op_t alu_op;
	logic [UW-1:0]    alu_sum;
	logic             alu_co;

	// divider, multiplier and root registers
	logic [UW-1:0]   rem_q;
	logic [NUMW-1:0] dn_q;
	logic [UW-1:0]   dv_q;
	logic [UW-1:0]   acc_q;
	logic [UW-1:0]   nq_q;
	logic [UW-1:0]   x_q;
	logic [UW-1:0]   res_q;
	logic [UW-1:0]   bit_q;
	logic [UW-1:0]   res_nxt;
	logic [SW-1:0]   mop_q;
	logic [DENW-1:0] den_q;

	// window accumulation
	logic signed [SW-1:0] s_q;
	logic [QW-1:0]        q_q;
	logic [NW-1:0]        n_q;
	logic [SW-1:0]        abs_s;
	logic [YW-1:0]        iss_y_q;
	logic [XW-1:0]        iss_x_q;
	logic [XW-1:0]        x1_q;
	logic [XW-1:0]        x2_q;
	logic [YW-1:0]        y2_q;
	logic                 iss_done_q;
	logic                 pend_q;
	logic [YW-1:0]        r_q;
	logic [XW-1:0]        c_q;

	// window bounds from the drain position
	logic [BW-1:0] rb, cb, radb, hb, wb;
	logic [BW-1:0] y1, y2, x1, x2;

	// pixels
	logic [lcn_pkg::PIX_W-1:0]        pix_q;
	logic [lcn_pkg::PIX_W-1:0]        rd_data;
	logic signed [lcn_pkg::PIX_W-1:0] rd_pix;
	logic signed [31:0]               rd_sq;
	logic [lcn_pkg::PIX_W-1:0]        abs_p;
	logic                             neg_q;
	logic [NUMW-1:0]                  quo;

	logic [MAW-1:0] raddr;
	logic [MAW-1:0] waddr;
	logic           we;

	logic signed [lcn_pkg::OUT_W-1:0] norm_q;
	logic                             last_q;

	assign busy      = (st_q != lcn_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign total     = CW'(w_q) * CW'(h_q);
	assign strobe    = strobe_q;
	assign norm_value = norm_q;
	assign last_pixel = last_q;

	// clamp config data on the way in
	always_comb begin
		if (cfg_data < 9'd2) begin
			cfg_w = WW'(2);
		end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
			cfg_w = WW'(MAX_WIDTH);
		end else begin
			cfg_w = WW'(cfg_data);
		end
		if (cfg_data < 9'd2) begin
			cfg_h = HW'(2);
		end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
			cfg_h = HW'(MAX_HEIGHT);
		end else begin
			cfg_h = HW'(cfg_data);
		end
		if (cfg_data[2:0] == 3'd0) begin
			cfg_r = RDW'(1);
		end else if (32'(cfg_data[2:0]) > 32'(MAX_RADIUS)) begin
			cfg_r = RDW'(MAX_RADIUS);
		end else begin
			cfg_r = RDW'(cfg_data[2:0]);
		end
	end

	// window bounds: rows max(r-R,0) .. min(r+R,H-1) exclusive, columns alike
	always_comb begin
		rb   = BW'(dn_q[YW-1:0]);
		cb   = BW'(rem_q[XW-1:0]);
		radb = BW'(rad_q);
		hb   = BW'(h_q) - BW'(1);
		wb   = BW'(w_q) - BW'(1);
		y1   = (rb > radb) ? rb - radb : '0;
		x1   = (cb > radb) ? cb - radb : '0;
		y2   = (rb + radb < hb) ? rb + radb : hb;
		x2   = (cb + radb < wb) ? cb + radb : wb;
	end

	assign rd_pix = $signed(rd_data);
	assign rd_sq  = rd_pix * rd_pix;
	assign abs_s  = s_q[SW-1] ? SW'(-s_q) : SW'(s_q);
	assign abs_p  = rd_pix[lcn_pkg::PIX_W-1] ? lcn_pkg::PIX_W'(-rd_pix) : rd_data;
	assign quo    = dn_q;

	// next root when the trial subtract fits
	assign res_nxt = alu_co ? ((res_q >> 1) | bit_q) : (res_q >> 1);

	// operand select for the shared unit
	always_comb begin
		alu_a  = '0;
		alu_b  = '0;
		alu_op = lcn_pkg::OP_ADD;
		case (st_q)
			lcn_pkg::ST_DIV: begin
				alu_a  = {rem_q[UW-2:0], dn_q[NUMW-1]};
				alu_b  = dv_q;
				alu_op = lcn_pkg::OP_SUB;
			end
			lcn_pkg::ST_MULN: begin
				alu_a = acc_q << 1;
				alu_b = mop_q[SW-1] ? UW'(q_q) : '0;
			end
			lcn_pkg::ST_MULS: begin
				alu_a = acc_q << 1;
				alu_b = mop_q[SW-1] ? UW'(abs_s) : '0;
			end
			lcn_pkg::ST_SUBD: begin
				alu_a  = nq_q;
				alu_b  = acc_q;
				alu_op = lcn_pkg::OP_SUB;
			end
			lcn_pkg::ST_SQRT: begin
				alu_a  = x_q;
				alu_b  = res_q | bit_q;
				alu_op = lcn_pkg::OP_SUB;
			end
			lcn_pkg::ST_RND: begin
				alu_a = UW'({abs_p, {lcn_pkg::FRAC_SHIFT{1'b0}}});
				alu_b = UW'(den_q >> 1);
			end
			default: begin
				alu_a  = '0;
				alu_b  = '0;
				alu_op = lcn_pkg::OP_ADD;
			end
		endcase
	end

	lcn_addsub #(.UW(UW)) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.op  (alu_op),
		.sum (alu_sum),
		.co  (alu_co)
	);

	// frame store addressing: row * MAX_WIDTH + column
	assign we    = (st_q == lcn_pkg::ST_LDWR);
	assign waddr = MAW'(dn_q[YW-1:0]) * MAW'(MAX_WIDTH) + MAW'(rem_q[XW-1:0]);
	assign raddr = (st_q == lcn_pkg::ST_WIN)
		? MAW'(iss_y_q) * MAW'(MAX_WIDTH) + MAW'(iss_x_q)
		: MAW'(r_q) * MAW'(MAX_WIDTH) + MAW'(c_q);

	lcn_frame_mem #(.DEPTH(DEPTH), .AW(MAW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (pix_q),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// control: sequencer, counters, config, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= lcn_pkg::ST_IDLE;
			kind_q     <= lcn_pkg::DK_LOAD;
			w_q        <= WW'(W_RST);
			h_q        <= HW'(H_RST);
			rad_q      <= RDW'(R_RST);
			load_cnt_q <= '0;
			emit_q     <= '0;
			strobe_q   <= 1'b0;
			cnt_q      <= '0;
			iss_done_q <= 1'b0;
			pend_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lcn_pkg::REG_IMG_WIDTH:     w_q   <= cfg_w;
					lcn_pkg::REG_IMG_HEIGHT:    h_q   <= cfg_h;
					lcn_pkg::REG_WINDOW_RADIUS: rad_q <= cfg_r;
					default: ;
				endcase
			end
			case (st_q)
				lcn_pkg::ST_IDLE: begin
					if (accept) begin
						if (!req_type) begin
							if (load_cnt_q < total) begin
								kind_q <= lcn_pkg::DK_LOAD;
								cnt_q  <= CTW'(CW);
								st_q   <= lcn_pkg::ST_DIV;
							end
						end else if (emit_q >= total) begin
							// stale position after a size change
							emit_q     <= '0;
							load_cnt_q <= '0;
						end else begin
							kind_q <= lcn_pkg::DK_DRAIN;
							cnt_q  <= CTW'(CW);
							st_q   <= lcn_pkg::ST_DIV;
						end
					end
				end
				lcn_pkg::ST_DIV: begin
					cnt_q <= cnt_q - CTW'(1);
					if (cnt_q == CTW'(1)) begin
						case (kind_q)
							lcn_pkg::DK_LOAD:  st_q <= lcn_pkg::ST_LDWR;
							lcn_pkg::DK_DRAIN: st_q <= lcn_pkg::ST_WSET;
							lcn_pkg::DK_SD:    st_q <= lcn_pkg::ST_DENS;
							default:           st_q <= lcn_pkg::ST_OUT;
						endcase
					end
				end
				lcn_pkg::ST_LDWR: begin
					load_cnt_q <= load_cnt_q + CW'(1);
					st_q       <= lcn_pkg::ST_IDLE;
				end
				lcn_pkg::ST_WSET: begin
					iss_done_q <= 1'b0;
					pend_q     <= 1'b0;
					st_q       <= lcn_pkg::ST_WIN;
				end
				lcn_pkg::ST_WIN: begin
					pend_q <= !iss_done_q;
					if (!iss_done_q && (iss_x_q + XW'(1) == x2_q)
						&& (iss_y_q + YW'(1) == y2_q)) begin
						iss_done_q <= 1'b1;
					end
					if (iss_done_q && !pend_q) begin
						cnt_q <= CTW'(NW);
						st_q  <= lcn_pkg::ST_MULN;
					end
				end
				lcn_pkg::ST_MULN: begin
					cnt_q <= cnt_q - CTW'(1);
					if (cnt_q == CTW'(1)) begin
						cnt_q <= CTW'(SW);
						st_q  <= lcn_pkg::ST_MULS;
					end
				end
				lcn_pkg::ST_MULS: begin
					cnt_q <= cnt_q - CTW'(1);
					if (cnt_q == CTW'(1)) begin
						st_q <= lcn_pkg::ST_SUBD;
					end
				end
				lcn_pkg::ST_SUBD: begin
					cnt_q <= CTW'(UW / 2);
					st_q  <= lcn_pkg::ST_SQRT;
				end
				lcn_pkg::ST_SQRT: begin
					cnt_q <= cnt_q - CTW'(1);
					if (cnt_q == CTW'(1)) begin
						kind_q <= lcn_pkg::DK_SD;
						cnt_q  <= CTW'(RW + 14);
						st_q   <= lcn_pkg::ST_DIV;
					end
				end
				lcn_pkg::ST_DENS: begin
					st_q <= lcn_pkg::ST_RND;
				end
				lcn_pkg::ST_RND: begin
					kind_q <= lcn_pkg::DK_QUO;
					cnt_q  <= CTW'(NUMW);
					st_q   <= lcn_pkg::ST_DIV;
				end
				lcn_pkg::ST_OUT: begin
					strobe_q <= 1'b1;
					if (emit_q == total - CW'(1)) begin
						emit_q     <= '0;
						load_cnt_q <= '0;
					end else begin
						emit_q <= emit_q + CW'(1);
					end
					st_q <= lcn_pkg::ST_IDLE;
				end
				default: st_q <= lcn_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			lcn_pkg::ST_IDLE: begin
				rem_q <= '0;
				if (!req_type) begin
					dn_q <= NUMW'(load_cnt_q) << (NUMW - CW);
				end else begin
					dn_q <= NUMW'(emit_q) << (NUMW - CW);
				end
				dv_q  <= UW'(w_q);
				pix_q <= pixel_in;
			end
			lcn_pkg::ST_DIV: begin
				// restoring division, one quotient bit a cycle
				rem_q <= alu_co ? alu_sum : alu_a;
				dn_q  <= {dn_q[NUMW-2:0], alu_co};
			end
			lcn_pkg::ST_WSET: begin
				r_q     <= dn_q[YW-1:0];
				c_q     <= rem_q[XW-1:0];
				iss_y_q <= YW'(y1);
				iss_x_q <= XW'(x1);
				x1_q    <= XW'(x1);
				x2_q    <= XW'(x2);
				y2_q    <= YW'(y2);
				s_q     <= '0;
				q_q     <= '0;
				n_q     <= '0;
			end
			lcn_pkg::ST_WIN: begin
				// one read issued, one pixel summed per cycle
				if (!iss_done_q) begin
					if (iss_x_q + XW'(1) == x2_q) begin
						iss_x_q <= x1_q;
						iss_y_q <= iss_y_q + YW'(1);
					end else begin
						iss_x_q <= iss_x_q + XW'(1);
					end
				end
				if (pend_q) begin
					s_q <= s_q + SW'(rd_pix);
					q_q <= q_q + QW'($unsigned(rd_sq));
					n_q <= n_q + NW'(1);
				end
				acc_q <= '0;
				mop_q <= SW'(n_q) << (SW - NW);
			end
			lcn_pkg::ST_MULN: begin
				// n * Q by shift and add
				acc_q <= alu_sum;
				mop_q <= mop_q << 1;
				if (cnt_q == CTW'(1)) begin
					nq_q  <= alu_sum;
					acc_q <= '0;
					mop_q <= abs_s;
				end
			end
			lcn_pkg::ST_MULS: begin
				// S * S by shift and add
				acc_q <= alu_sum;
				mop_q <= mop_q << 1;
			end
			lcn_pkg::ST_SUBD: begin
				x_q   <= alu_sum;
				res_q <= '0;
				bit_q <= UW'(1) << (UW - 2);
			end
			lcn_pkg::ST_SQRT: begin
				// digit-by-digit integer root
				if (alu_co) begin
					x_q <= alu_sum;
				end
				res_q <= res_nxt;
				bit_q <= bit_q >> 2;
				if (cnt_q == CTW'(1)) begin
					rem_q <= '0;
					dn_q  <= NUMW'(res_nxt[RW-1:0]) << (NUMW - RW);
					dv_q  <= UW'(n_q);
				end
			end
			lcn_pkg::ST_DENS: begin
				den_q <= DENW'(dn_q[RW+13:0]) + DENW'(lcn_pkg::BIAS_Q28);
			end
			lcn_pkg::ST_RND: begin
				// round to nearest: add half the divisor before dividing
				rem_q <= '0;
				dn_q  <= alu_sum[NUMW-1:0];
				dv_q  <= UW'(den_q);
				neg_q <= rd_pix[lcn_pkg::PIX_W-1];
			end
			lcn_pkg::ST_OUT: begin
				if (neg_q) begin
					norm_q <= (quo > NUMW'(lcn_pkg::OUT_NEG_MIN))
						? $signed(lcn_pkg::OUT_NEG_MIN)
						: $signed(lcn_pkg::OUT_W'(-quo));
				end else begin
					norm_q <= (quo > NUMW'(lcn_pkg::OUT_POS_MAX))
						? $signed(lcn_pkg::OUT_POS_MAX)
						: $signed(lcn_pkg::OUT_W'(quo));
				end
				last_q <= (emit_q == total - CW'(1));
			end
			default: ;
		endcase
	end
endmodule

// File: hdl/lcn_addsub.sv
// shared wide add/subtract unit with carry out (no borrow on subtract)
module lcn_addsub #(
	parameter int UW = 48
) (
	input  logic [UW-1:0]     a,
	input  logic [UW-1:0]     b,
	input  lcn_pkg::alu_op_t  op,
	output logic [UW-1:0]     sum,
	output logic              co
);
	logic [UW-1:0] b_eff;

	assign b_eff = (op == lcn_pkg::OP_SUB) ? ~b : b;
	assign {co, sum} = {1'b0, a} + {1'b0, b_eff} + {{UW{1'b0}}, (op == lcn_pkg::OP_SUB)};
endmodule

// File: hdl/lcn_frame_mem.sv
// frame store, one write port and one registered read port
module lcn_frame_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [lcn_pkg::PIX_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [lcn_pkg::PIX_W-1:0] rdata
);
	logic [lcn_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/lcn_checker.sv
// port-level checks for the local contrast normalizer, bound to the top
`include "assert_macros.svh"

module lcn_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic req_type,
	input logic strobe
);
	// a result shows only once the sequencer is back to idle
	`AST_IMP(a_strobe_idle, strobe, !busy)
	// a load beat never produces a result
	`AST_NXT(a_load_silent, start && !busy && !req_type, !strobe)
	// every result comes from work done in the cycle before
	`AST_IMP(a_strobe_after_work, strobe, $past(busy))
endmodule

bind local_contrast_normalize lcn_checker u_lcn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.req_type (req_type),
	.strobe   (strobe)
);

// File: dv/tb.sv
// testbench for the local contrast normalizer: directed and random frames, self-checking
`timescale 1ns / 100ps

module tb;
	import lcn_pkg::*;

	localparam int MAXW = 256;
	localparam int MAXH = 256;
	localparam int MAXR = 7;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 6000000;

	typedef struct {
		logic signed [OUT_W-1:0] norm;
		logic                    last;
	} norm_beat_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    req_type;
	logic signed [PIX_W-1:0] pixel_in;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [1:0]              cfg_index;
	logic [8:0]              cfg_data;
	logic                    strobe;
	logic signed [OUT_W-1:0] norm_value;
	logic                    last_pixel;

	// mirror of the block: registers, counters and pixel store
	logic [8:0]  mir_width;
	logic [8:0]  mir_height;
	logic [2:0]  mir_radius;
	int          load_idx;
	int          emit_idx;
	logic [15:0] pix_store [0:MAXW*MAXH-1];
	bit          pix_written [0:MAXW*MAXH-1];

	norm_beat_t  norm_q [$];
	int          errors;
	longint      cycles;
	bit          idle_on;
	bit          frame_closed;
	int          random_beats;

	local_contrast_normalize dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .pixel_in(pixel_in),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .norm_value(norm_value), .last_pixel(last_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_w();
		return (mir_width < 2) ? 2 : (mir_width > MAXW) ? MAXW : int'(mir_width);
	endfunction

	function automatic int eff_h();
		return (mir_height < 2) ? 2 : (mir_height > MAXH) ? MAXH : int'(mir_height);
	endfunction

	function automatic int eff_rad();
		return (mir_radius < 1) ? 1 : (mir_radius > MAXR) ? MAXR : int'(mir_radius);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint pix_val(int r, int c);
		return longint'($signed(pix_store[(r * MAXW + c) % (MAXW * MAXH)]));
	endfunction

	// window bounds: upper row and column are exclusive, so the last row/col never enter
	function automatic void win_bounds(int r, int c, output int y1, output int y2,
			output int x1, output int x2);
		int rad;
		rad = eff_rad();
		y1 = (r > rad) ? r - rad : 0;
		x1 = (c > rad) ? c - rad : 0;
		y2 = (r + rad < eff_h() - 1) ? r + rad : eff_h() - 1;
		x2 = (c + rad < eff_w() - 1) ? c + rad : eff_w() - 1;
	endfunction

	// a drain is legal only when every pixel it reads has been written since reset
	function automatic bit drain_is_safe();
		int r, c, y1, y2, x1, x2;
		if (emit_idx >= eff_w() * eff_h())
			return 1'b1;
		r = emit_idx / eff_w();
		c = emit_idx % eff_w();
		if (!pix_written[r * MAXW + c])
			return 1'b0;
		win_bounds(r, c, y1, y2, x1, x2);
		for (int y = y1; y < y2; y++)
			for (int x = x1; x < x2; x++)
				if (!pix_written[y * MAXW + x])
					return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic signed [OUT_W-1:0] normalized_pixel(int r, int c);
		int y1, y2, x1, x2;
		longint s, p, res;
		longint unsigned q, n, d, sd28, den, num, quo;
		win_bounds(r, c, y1, y2, x1, x2);
		s = 0;
		q = 0;
		n = 0;
		for (int y = y1; y < y2; y++)
			for (int x = x1; x < x2; x++) begin
				p = pix_val(y, x);
				s += p;
				q += longint'(p * p);
				n++;
			end
		d = n * q - longint'(s * s);
		sd28 = (int_sqrt(d) << 14) / n;
		den = sd28 + BIAS_Q28;
		p = pix_val(r, c);
		num = longint'(p < 0 ? -p : p) << 28;
		quo = (num + den / 2) / den;
		res = (p < 0) ? -longint'(quo) : longint'(quo);
		if (res > 8388607)
			res = 8388607;
		if (res < -8388608)
			res = -8388608;
		return res[OUT_W-1:0];
	endfunction

	// advance the mirror by one accepted beat; push the result it causes, if any
	task automatic predict_beat(input bit is_drain, input logic [15:0] px);
		int total, r, c;
		norm_beat_t nb;
		total = eff_w() * eff_h();
		if (!is_drain) begin
			if (load_idx < total) begin
				r = load_idx / eff_w();
				c = load_idx % eff_w();
				pix_store[r * MAXW + c] = px;
				pix_written[r * MAXW + c] = 1'b1;
				load_idx++;
			end
		end else if (emit_idx >= total) begin
			// stale drain position after a size change: no result, counters restart
			emit_idx = 0;
			load_idx = 0;
		end else begin
			r = emit_idx / eff_w();
			c = emit_idx % eff_w();
			nb.norm = normalized_pixel(r, c);
			nb.last = (emit_idx == total - 1);
			norm_q.push_back(nb);
			if (nb.last) begin
				emit_idx = 0;
				load_idx = 0;
				frame_closed = 1'b1;
			end else begin
				emit_idx++;
			end
		end
	endtask

	// one command beat: drive on the falling edge, accepted when start and !busy at the rise
	task automatic send_beat(input bit is_drain, input logic [15:0] px);
		if (idle_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 5)) @(negedge clk);
		@(negedge clk);
		start = 1'b1;
		req_type = is_drain;
		pixel_in = px;
		do @(posedge clk); while (busy);
		predict_beat(is_drain, px);
		@(negedge clk);
		start = 1'b0;
		req_type = $urandom_range(0, 1);
		pixel_in = $urandom;
	endtask

	// hold off until every result is in and the block has gone quiet
	task automatic wait_quiet();
		wait (norm_q.size() == 0);
		@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		wait_quiet();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IMG_WIDTH:     mir_width = val;
			REG_IMG_HEIGHT:    mir_height = val;
			REG_WINDOW_RADIUS: mir_radius = val[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_geometry(input logic [8:0] w, input logic [8:0] h, input logic [8:0] rad);
		write_reg(REG_IMG_WIDTH, w);
		write_reg(REG_IMG_HEIGHT, h);
		write_reg(REG_WINDOW_RADIUS, rad);
	endtask

	function automatic logic [15:0] pick_pixel(int pattern, logic [15:0] flat);
		case (pattern)
			0: return $urandom;
			1: return 16'($signed($urandom_range(0, 63)) - 32);
			2: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
			3: return ($urandom_range(0, 7) == 0) ? 16'($urandom) : flat;
			default: return $urandom;
		endcase
	endfunction

	// whole frame in raster order, then all drains
	task automatic run_frame_straight(input int pattern);
		int total;
		logic [15:0] flat;
		total = eff_w() * eff_h();
		flat = $urandom;
		for (int i = 0; i < total; i++)
			send_beat(1'b0, pick_pixel(pattern, flat));
		for (int i = 0; i < total; i++)
			send_beat(1'b1, 16'h0);
	endtask

	// directed: smallest frame, full-scale pixels, smallest radius, then a flat 3 x 3 frame at radius 7
	task automatic test_extremes();
		set_geometry(9'd2, 9'd2, 9'd1);
		send_beat(1'b0, 16'h8000);
		send_beat(1'b0, 16'h7FFF);
		send_beat(1'b0, 16'h0000);
		send_beat(1'b0, 16'hFFFF);
		send_beat(1'b0, 16'h1234);   // beyond the frame, ignored
		repeat (4) send_beat(1'b1, 16'h0);
		set_geometry(9'd3, 9'd3, 9'd7);
		send_beat(1'b0, 16'h0001);
		repeat (8) send_beat(1'b0, 16'h0001);   // flat window, zero deviation
		repeat (9) send_beat(1'b1, 16'h0);
	endtask

	// directed: drain stranded past the end of a shrunk frame
	task automatic test_stale_position();
		set_geometry(9'd4, 9'd4, 9'd1);
		for (int i = 0; i < 16; i++)
			send_beat(1'b0, $urandom);
		repeat (5) send_beat(1'b1, 16'h0);
		set_geometry(9'd2, 9'd2, 9'd1);
		send_beat(1'b1, 16'h0);   // no result, counters restart
		run_frame_straight(0);
	endtask

	// directed: out-of-range register values clamp, unused index ignored, widest frames
	task automatic test_clamping();
		write_reg(REG_UNUSED, 9'h1FF);
		set_geometry(9'd0, 9'd511, 9'd0);
		run_frame_straight(0);
		set_geometry(9'd300, 9'd1, 9'd7);
		run_frame_straight(2);
		set_geometry(9'd256, 9'd2, 9'd4);
		write_reg(REG_UNUSED, 9'h000);
		run_frame_straight(1);
	endtask

	// random frames: mostly well-formed with loads and early drains interleaved, some noise
	task automatic test_random_frames(input int beat_goal);
		int pattern;
		logic [15:0] flat;
		int total;
		while (random_beats < beat_goal) begin
			if (random_beats > beat_goal - 200)
				idle_on = 1'b0;
			case ($urandom_range(0, 9))
				0: set_geometry($urandom_range(0, 1), $urandom_range(2, 6), $urandom_range(0, 7));
				1: set_geometry($urandom_range(2, 20), $urandom_range(2, 4), 9'd7);
				default: set_geometry($urandom_range(2, 12), $urandom_range(2, 10),
					$urandom_range(1, 7));
			endcase
			pattern = $urandom_range(0, 3);
			flat = $urandom;
			total = eff_w() * eff_h();
			frame_closed = 1'b0;
			while (!frame_closed) begin
				if (load_idx < total && ($urandom_range(0, 3) != 0 || !drain_is_safe())) begin
					send_beat(1'b0, pick_pixel(pattern, flat));
					random_beats++;
				end else if (load_idx >= total && $urandom_range(0, 30) == 0) begin
					send_beat(1'b0, $urandom);   // past the frame, ignored
				end else begin
					send_beat(1'b1, 16'h0);
					random_beats++;
				end
				if ($urandom_range(0, 150) == 0)
					wait_quiet();
			end
		end
	endtask

	// result check on every strobe
	always @(posedge clk) begin
		norm_beat_t nb;
		if (arst_n && strobe) begin
			if (norm_q.size() == 0) begin
				$display("%0t: unexpected result norm_value=%0d last_pixel=%0b",
					$time, norm_value, last_pixel);
				errors++;
			end else begin
				nb = norm_q.pop_front();
				if (norm_value !== nb.norm) begin
					$display("%0t: norm_value expected %0d actual %0d",
						$time, nb.norm, norm_value);
					errors++;
				end
				if (last_pixel !== nb.last) begin
					$display("%0t: last_pixel expected %0b actual %0b",
						$time, nb.last, last_pixel);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		idle_on = 1'b1;
		random_beats = 0;
		frame_closed = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = 1'b0;
		pixel_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mir_width = 9'd256;
		mir_height = 9'd256;
		mir_radius = 3'd3;
		load_idx = 0;
		emit_idx = 0;
		for (int i = 0; i < MAXW * MAXH; i++) begin
			pix_store[i] = '0;
			pix_written[i] = 1'b0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_stale_position();
		test_clamping();
		test_random_frames(1250);

		wait_quiet();
		repeat (50) @(posedge clk);
		if (errors == 0 && norm_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/lcn_pkg.sv
hdl/lcn_addsub.sv
hdl/lcn_frame_mem.sv
hdl/local_contrast_normalize.sv
hdl/lcn_checker.sv
dv/tb.sv
